[rtl/core/bist_pkg.sv]
// Package with sizes, request codes and controller types for the bounded integer set table.
`default_nettype none
package bist_pkg;

    localparam int CAPACITY = 128;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 8;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_EXEC,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic idx_inc;
        logic idx_from_slot;
        logic hit;
        logic rd_en;
        logic wr_append;
        logic wr_shift;
        logic cnt_inc;
        logic cnt_dec;
        logic acc_set;
        logic acc_val;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             at_end;
        logic             match;
        logic             found;
        logic             full;
        logic [CNT_W-1:0] count;
    } dp_status_t;

    function automatic logic [POS_W-1:0] to_position(input logic [IDX_W-1:0] slot);
        logic [IDX_W+POS_W-1:0] wide;
        wide = {{POS_W{1'b0}}, slot};
        return wide[POS_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] to_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+COUNT_W-1:0] wide;
        wide = {{COUNT_W{1'b0}}, cnt};
        return wide[COUNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

[rtl/core/bist_dp.sv]
// Datapath of the set table: element memory, scan index, count and result registers.
`default_nettype none
module bist_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bist_pkg::dp_cmd_t            cmd,
    output bist_pkg::dp_status_t         status,
    input  logic [bist_pkg::OP_W-1:0]    op,
    input  logic signed [bist_pkg::VAL_W-1:0] value,
    output logic                         accepted,
    output logic                         found,
    output logic [bist_pkg::POS_W-1:0]   position,
    output logic [bist_pkg::COUNT_W-1:0] count,
    output logic                         is_full,
    output logic                         is_empty
);
    import bist_pkg::*;

    logic [VAL_W-1:0] mem [CAPACITY];

    logic [OP_W-1:0]    op_reg;
    logic [VAL_W-1:0]   value_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic [CNT_W-1:0]   idx_dec;
    logic [IDX_W-1:0]   slot_reg;
    logic               found_reg;
    logic               acc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [VAL_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]   wr_addr;
    logic               cnt_full;

    logic               accepted_reg;
    logic               found_out_reg;
    logic [POS_W-1:0]   position_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               is_full_reg;
    logic               is_empty_reg;

    assign idx_dec  = idx_reg - 1'b1;
    assign cnt_full = (cnt_reg == CNT_W'(CAPACITY));
    assign wr_addr  = cmd.wr_append ? cnt_reg[IDX_W-1:0] : idx_dec[IDX_W-1:0];

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.capture)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_from_slot)
        begin
            idx_next = CNT_W'(slot_reg) + 1'b1;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (cmd.cnt_dec)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.capture)
        begin
            op_reg    <= op;
            value_reg <= $unsigned(value);
            found_reg <= 1'b0;
            slot_reg  <= '0;
            acc_reg   <= 1'b0;
        end
        if (cmd.hit)
        begin
            found_reg <= 1'b1;
            slot_reg  <= idx_reg[IDX_W-1:0];
        end
        if (cmd.acc_set)
        begin
            acc_reg <= cmd.acc_val;
        end
        if (cmd.load_out)
        begin
            accepted_reg  <= acc_reg;
            found_out_reg <= found_reg;
            position_reg  <= found_reg ? to_position(slot_reg) : '0;
            count_reg     <= to_count(cnt_reg);
            is_full_reg   <= cnt_full;
            is_empty_reg  <= (cnt_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
        if (cmd.wr_append)
        begin
            mem[wr_addr] <= value_reg;
        end
        else if (cmd.wr_shift)
        begin
            mem[wr_addr] <= rd_data_reg;
        end
    end

    assign status.op     = op_reg;
    assign status.at_end = (idx_reg == cnt_reg);
    assign status.match  = (rd_data_reg == value_reg);
    assign status.found  = found_reg;
    assign status.full   = cnt_full;
    assign status.count  = cnt_reg;

    assign accepted = accepted_reg;
    assign found    = found_out_reg;
    assign position = position_reg;
    assign count    = count_reg;
    assign is_full  = is_full_reg;
    assign is_empty = is_empty_reg;

endmodule
`default_nettype wire

[rtl/core/bist_ctrl.sv]
// Controller state machine that sequences the scan, append, shift and result hand-off.
`default_nettype none
module bist_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bist_pkg::dp_status_t status,
    output bist_pkg::dp_cmd_t    cmd
);
    import bist_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = status.at_end ? ST_EXEC : ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                state_next = status.match ? ST_EXEC : ST_SCAN_RD;
            end
            ST_EXEC:
            begin
                if ((status.op == OP_DEL) && status.found)
                begin
                    state_next = ST_SHIFT_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT_RD:
            begin
                state_next = status.at_end ? ST_FINISH : ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                state_next = ST_SHIFT_RD;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture = in_valid;
            end
            ST_SCAN_RD:
            begin
                cmd.rd_en = !status.at_end;
            end
            ST_SCAN_CMP:
            begin
                cmd.hit     = status.match;
                cmd.idx_inc = !status.match;
            end
            ST_EXEC:
            begin
                cmd.acc_set = 1'b1;
                case (status.op)
                    OP_ADD:
                    begin
                        if (!status.full)
                        begin
                            cmd.acc_val   = 1'b1;
                            cmd.wr_append = !status.found;
                            cmd.cnt_inc   = !status.found;
                        end
                    end
                    OP_DEL:
                    begin
                        cmd.acc_val       = status.found;
                        cmd.idx_from_slot = status.found;
                    end
                    OP_QUERY:
                    begin
                        cmd.acc_val = status.found;
                    end
                    default:
                    begin
                        cmd.acc_val = 1'b0;
                    end
                endcase
            end
            ST_SHIFT_RD:
            begin
                cmd.rd_en   = !status.at_end;
                cmd.cnt_dec = status.at_end;
            end
            ST_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_out = out_free;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[rtl/core/bounded_integer_set_table_core.sv]
// Top level of the bounded integer set table: controller, datapath and checks.
// Each request scans the stored entries in order (a read, then a compare per entry, up to
// 128 entries) and then executes; a delete that finds its value then shifts the later
// entries down. Requests are taken one at a time: in_ready is high only while idle, which
// the block re-enters as its result is issued; a result not yet taken stalls the block.
// Reset clears the count and the controller; memory contents need no clearing.
`default_nettype none
module bounded_integer_set_table_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bist_pkg::OP_W-1:0]            op,
    input  logic signed [bist_pkg::VAL_W-1:0]    value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 accepted,
    output logic                                 found,
    output logic [bist_pkg::POS_W-1:0]           position,
    output logic [bist_pkg::COUNT_W-1:0]         count,
    output logic                                 is_full,
    output logic                                 is_empty
);
    import bist_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bist_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .op       (op),
        .value    (value),
        .accepted (accepted),
        .found    (found),
        .position (position),
        .count    (count),
        .is_full  (is_full),
        .is_empty (is_empty)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.count <= CNT_W'(CAPACITY))
        else $error("Element count exceeds capacity.");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("Block took a request while another was in progress.");

    a_no_grow_and_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.cnt_inc && cmd.cnt_dec))
        else $error("Count incremented and decremented in the same cycle.");

    a_position_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> position == '0)
        else $error("Nonzero position reported for an absent value.");

endmodule
`default_nettype wire
